// ----- rtl/lkvc_pkg.sv -----
// ----------------------------------------------------------------------------
// lkvc_pkg
// Shared types and constants for the LRU key-value cache.
// ----------------------------------------------------------------------------
package lkvc_pkg;

  // Fixed widths of the stream payload and the configuration register.
  localparam int unsigned FieldBits   = 32;
  localparam int unsigned STdataBits  = 2 * FieldBits;
  localparam int unsigned MTdataBits  = FieldBits;
  localparam int unsigned CfgBits     = 5;
  localparam logic [CfgBits-1:0] CapReset = 5'd16;

  // Operation carried on the request side-band.
  typedef enum logic {
    KIND_LOOKUP = 1'b0,
    KIND_STORE  = 1'b1
  } kind_e;

  // Command to the recency tracker.
  typedef enum logic [1:0] {
    RANK_HOLD,
    RANK_TOUCH,
    RANK_FILL
  } rank_op_e;

endpackage

// ----- rtl/lkvc_recency.sv -----
// ----------------------------------------------------------------------------
// lkvc_recency
// Per-entry recency ranks (0 = most recent) and the oldest-entry search.
// ----------------------------------------------------------------------------
module lkvc_recency #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  lkvc_pkg::rank_op_e                       op_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] idx_i,
  input  logic [$clog2(DEPTH + 1)-1:0]             count_i,
  output logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] oldest_o
);
  import lkvc_pkg::*;

  localparam int unsigned IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [IdxW-1:0] rank_q [DEPTH];
  logic [CntW-1:0] ref_rank;
  logic [CntW-1:0] last_rank;

  // Entries with a rank below the reference age by one.
  always_comb begin
    unique case (op_i)
      RANK_FILL:  ref_rank = count_i;
      RANK_TOUCH: ref_rank = CntW'(rank_q[idx_i]);
      default:    ref_rank = '0;
    endcase
  end

  assign last_rank = count_i - CntW'(1);

  always_comb begin
    oldest_o = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if ((CntW'(i) < count_i) && (CntW'(rank_q[i]) == last_rank)) begin
        oldest_o = IdxW'(i);
      end
    end
  end

  // The target entry takes rank 0; the others age or hold.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) begin
        rank_q[i] <= '0;
      end
    end else if (op_i != RANK_HOLD) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (IdxW'(i) == idx_i) begin
          rank_q[i] <= '0;
        end else if ((CntW'(i) < count_i) && (CntW'(rank_q[i]) < ref_rank)) begin
          rank_q[i] <= rank_q[i] + IdxW'(1);
        end
      end
    end
  end

endmodule

// ----- rtl/lru_key_value_cache.sv -----
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key-value store with least-recently-used replacement.
// ----------------------------------------------------------------------------
//
//  channel   | dir | payload                           | handshake
//  ----------+-----+-----------------------------------+----------------------
//  s_axis    | in  | tuser: kind; tdata: key, value    | tvalid & tready
//  m_axis    | out | tuser: hit;  tdata: read_value    | tvalid & tready
//  cfg       | in  | cfg_wdata_i: capacity_limit       | cfg_we_i
//
//  One request per cycle sustained while the output is not stalled. A request
//  sits in the input register, where the key compare against all entries,
//  the recency update and the replacement choice happen; its response lands
//  in the output register at the edge on which it leaves the input register.
//  Reset empties the cache (fill count zero) and sets the capacity to 16.
//  A stalled output holds the response and the request behind it; s_axis
//  stays ready while the input register is empty or draining.
// ----------------------------------------------------------------------------
module lru_key_value_cache #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned KEY_BITS   = 32,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // request stream
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [lkvc_pkg::STdataBits-1:0]      s_axis_tdata,  // [31:0] key, [63:32] value
  input  lkvc_pkg::kind_e                      s_axis_tuser,  // [0] kind
  // response stream
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [lkvc_pkg::MTdataBits-1:0]      m_axis_tdata,  // [31:0] read_value
  output logic                                 m_axis_tuser,  // [0] hit
  // configuration
  input  logic                                 cfg_we_i,
  input  logic [lkvc_pkg::CfgBits-1:0]         cfg_wdata_i     // capacity_limit
);
  import lkvc_pkg::*;

  localparam int unsigned KeyW = (KEY_BITS < FieldBits) ? KEY_BITS : FieldBits;
  localparam int unsigned ValW = (VALUE_BITS < FieldBits) ? VALUE_BITS : FieldBits;
  localparam int unsigned IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned CapW = (CntW > CfgBits) ? CntW : CfgBits;

  // Configuration
  logic [CfgBits-1:0] cap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CapReset;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  // Input register
  logic            in_valid_q;
  kind_e           in_kind_q;
  logic [KeyW-1:0] in_key_q;
  logic [ValW-1:0] in_val_q;
  logic            advance;
  logic            s_fire;

  assign advance       = in_valid_q && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_kind_q <= s_axis_tuser;
      in_key_q  <= s_axis_tdata[KeyW-1:0];
      in_val_q  <= s_axis_tdata[FieldBits +: ValW];
    end
  end

  // Entry storage; entries below the fill count are in use
  logic [KeyW-1:0] key_q [DEPTH];
  logic [ValW-1:0] val_q [DEPTH];
  logic [CntW-1:0] count_q;

  // Effective capacity: zero acts as one, saturate at DEPTH
  logic [CapW-1:0] cap_ext;
  logic [CapW-1:0] cap_eff;
  logic            has_room;

  assign cap_ext  = CapW'(cap_q);
  assign cap_eff  = (cap_ext == '0) ? CapW'(1) :
                    (cap_ext > CapW'(DEPTH)) ? CapW'(DEPTH) : cap_ext;
  assign has_room = CapW'(count_q) < cap_eff;

  // Associative compare over all in-use entries; keys are distinct
  logic            hit;
  logic [IdxW-1:0] hit_idx;
  logic [ValW-1:0] hit_val;

  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    hit_val = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if ((CntW'(i) < count_q) && (key_q[i] == in_key_q)) begin
        hit     = 1'b1;
        hit_idx = hit_idx | IdxW'(i);
        hit_val = hit_val | val_q[i];
      end
    end
  end

  // Decide the update: touch on any hit, fill a free slot on a stored new key
  // while below capacity, otherwise replace the oldest entry; a lookup miss changes nothing.
  logic            is_store;
  rank_op_e        rank_op;
  logic [IdxW-1:0] tgt_idx;
  logic [IdxW-1:0] oldest_idx;
  logic            wr_key;
  logic            wr_val;
  logic [CntW-1:0] count_d;
  logic [ValW-1:0] rd_val;

  assign is_store = (in_kind_q == KIND_STORE);

  always_comb begin
    rank_op = RANK_HOLD;
    tgt_idx = hit_idx;
    wr_key  = 1'b0;
    wr_val  = 1'b0;
    count_d = count_q;
    if (advance) begin
      if (hit) begin
        rank_op = RANK_TOUCH;
        wr_val  = is_store;
      end else if (is_store) begin
        wr_key = 1'b1;
        wr_val = 1'b1;
        if (has_room) begin
          rank_op = RANK_FILL;
          tgt_idx = count_q[IdxW-1:0];
          count_d = count_q + CntW'(1);
        end else begin
          rank_op = RANK_TOUCH;
          tgt_idx = oldest_idx;
        end
      end
    end
  end

  assign rd_val = (!is_store && hit) ? hit_val : '0;

  lkvc_recency #(
    .DEPTH (DEPTH)
  ) u_recency (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .op_i     (rank_op),
    .idx_i    (tgt_idx),
    .count_i  (count_q),
    .oldest_o (oldest_idx)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_key) begin
      key_q[tgt_idx] <= in_key_q;
    end
    if (wr_val) begin
      val_q[tgt_idx] <= in_val_q;
    end
  end

  // Output register
  logic            out_hit_q;
  logic [ValW-1:0] out_val_q;
  logic            out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_hit_q <= hit;
      out_val_q <= rd_val;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_hit_q;
  assign m_axis_tdata  = MTdataBits'(out_val_q);

endmodule
